[rtl/core/hard_sphere_insertion_overlap_assert.svh]
// Assertion macros shared by the overlap checker.
`ifndef HARD_SPHERE_INSERTION_OVERLAP_ASSERT_SVH
`define HARD_SPHERE_INSERTION_OVERLAP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define HSIO_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("hsio assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSIO_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("hsio assertion failed");

`else

`define HSIO_ASSERT_NOW(label, clk, rst_n, cond, cons)
`define HSIO_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

[rtl/core/hsio_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hsio_pkg;

    localparam int COORD_W     = 24;
    localparam int CNT_W       = 32;
    localparam int PCOUNT_W    = 11;
    localparam int SLOT_W      = 10;
    // Wide enough to hold any particle index up to the largest store.
    localparam int IDX_W       = 17;
    localparam int CELLS       = 4;
    localparam int CELL_BITS   = 2;
    localparam int ROW_FIELD_W = IDX_W - CELL_BITS;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CNT_W-1:0]   count_t;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TEST  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    localparam logic [1:0] CFG_BOX_X = 2'd0;
    localparam logic [1:0] CFG_BOX_Y = 2'd1;
    localparam logic [1:0] CFG_BOX_Z = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Work token that travels down the chain of cells.
    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic                   hit;
        logic                   inr;
        logic [ROW_FIELD_W-1:0] row;
        coord_t                 px;
        coord_t                 py;
        coord_t                 pz;
    } tok_t;

    // Settings shared by every cell.
    typedef struct packed {
        coord_t           box_x;
        coord_t           box_y;
        coord_t           box_z;
        logic [IDX_W-1:0] limit;
    } cfg_t;

    // Store write broadcast to every cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] slot;
        coord_t           x;
        coord_t           y;
        coord_t           z;
    } wr_t;

endpackage

`default_nettype wire

[rtl/core/hsio_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module hsio_cell
    import hsio_pkg::*;
#(
    parameter int CELL_INDEX    = 0,
    parameter int MAX_PARTICLES = 1024,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire wr_t  wr,
    input  wire tok_t tok_in,
    output tok_t      tok_out
);

    localparam int ROWS  = (MAX_PARTICLES + CELLS - 1) / CELLS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [49:0] UNIT = 50'(1) << (2 * FRACTION_BITS);
    localparam logic [CELL_BITS-1:0] MY_LANE = CELL_BITS'(CELL_INDEX);

    // Slot s lives in lane s mod CELLS, at row s / CELLS.
    coord_t mem_x [ROWS];
    coord_t mem_y [ROWS];
    coord_t mem_z [ROWS];

    coord_t rd_x_reg, rd_y_reg, rd_z_reg;
    tok_t   s1_tok_reg, s2_tok_reg, s3_tok_reg, s4_tok_reg, out_tok_reg;
    tok_t   s1_tok_next, out_tok_next;

    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic signed [24:0] dx_next, dy_next, dz_next;
    logic signed [24:0] mx_reg, my_reg, mz_reg;
    logic signed [24:0] mx_next, my_next, mz_next;
    logic [47:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [47:0]        sqx_next, sqy_next, sqz_next;
    logic signed [49:0] px2, py2, pz2;
    logic [49:0]        dist2;

    function automatic logic signed [24:0] min_image(input logic signed [24:0] d,
                                                     input coord_t b);
        logic signed [25:0] twice;
        logic signed [25:0] bs;
        logic signed [24:0] bd;
        logic signed [24:0] r;
        twice = {d, 1'b0};
        bs    = $signed({2'b00, b});
        bd    = $signed({1'b0, b});
        if (twice > bs)
            r = d - bd;
        else if (twice < -bs)
            r = d + bd;
        else
            r = d;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.slot[CELL_BITS-1:0] == MY_LANE))
        begin
            mem_x[wr.slot[CELL_BITS +: ROW_W]] <= wr.x;
            mem_y[wr.slot[CELL_BITS +: ROW_W]] <= wr.y;
            mem_z[wr.slot[CELL_BITS +: ROW_W]] <= wr.z;
        end
        rd_x_reg <= mem_x[tok_in.row[ROW_W-1:0]];
        rd_y_reg <= mem_y[tok_in.row[ROW_W-1:0]];
        rd_z_reg <= mem_z[tok_in.row[ROW_W-1:0]];
    end

    always_comb
    begin
        s1_tok_next     = tok_in;
        s1_tok_next.inr = (IDX_W'({tok_in.row[ROW_W-1:0], MY_LANE}) < cfg.limit);

        dx_next = $signed({1'b0, s1_tok_reg.px}) - $signed({1'b0, rd_x_reg});
        dy_next = $signed({1'b0, s1_tok_reg.py}) - $signed({1'b0, rd_y_reg});
        dz_next = $signed({1'b0, s1_tok_reg.pz}) - $signed({1'b0, rd_z_reg});

        mx_next = min_image(dx_reg, cfg.box_x);
        my_next = min_image(dy_reg, cfg.box_y);
        mz_next = min_image(dz_reg, cfg.box_z);

        px2      = mx_reg * mx_reg;
        py2      = my_reg * my_reg;
        pz2      = mz_reg * mz_reg;
        sqx_next = px2[47:0];
        sqy_next = py2[47:0];
        sqz_next = pz2[47:0];

        dist2            = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};
        out_tok_next     = s4_tok_reg;
        out_tok_next.hit = s4_tok_reg.hit
                           | (s4_tok_reg.valid & s4_tok_reg.inr & (dist2 < UNIT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg  <= '0;
            s2_tok_reg  <= '0;
            s3_tok_reg  <= '0;
            s4_tok_reg  <= '0;
            out_tok_reg <= '0;
        end
        else
        begin
            s1_tok_reg  <= s1_tok_next;
            s2_tok_reg  <= s1_tok_reg;
            s3_tok_reg  <= s2_tok_reg;
            s4_tok_reg  <= s3_tok_reg;
            out_tok_reg <= out_tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        mz_reg  <= mz_next;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        sqz_reg <= sqz_next;
    end

    assign tok_out = out_tok_reg;

endmodule

`default_nettype wire

[rtl/core/hsio_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module hsio_ctrl
    import hsio_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [COORD_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        operation,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire coord_t            pos_x,
    input  wire coord_t            pos_y,
    input  wire coord_t            pos_z,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   overlap,
    output count_t                 accepted_count,
    output count_t                 trial_count,
    output cfg_t                   cfg,
    output wr_t                    wr,
    output tok_t                   issue_tok,
    input  wire tok_t              chain_tok
);

    localparam int ROWS   = (MAX_PARTICLES + CELLS - 1) / CELLS;
    localparam int RCNT_W = $clog2(ROWS + 1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PARTICLES);
    localparam count_t SAT = '1;

    state_t state_reg, state_next;

    coord_t               box_x_reg, box_y_reg, box_z_reg;
    logic [PCOUNT_W-1:0]  count_reg;

    logic [1:0]           op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    coord_t               px_reg, py_reg, pz_reg;

    logic [RCNT_W-1:0]    row_reg, row_next;
    logic                 ovl_reg, ovl_next;
    tok_t                 issue_tok_reg, issue_tok_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 overlap_reg, overlap_next;
    count_t               acc_reg, acc_next;
    count_t               trial_reg, trial_next;

    logic [IDX_W-1:0]     count_ext, limit, rows;
    logic [RCNT_W-1:0]    rows_w;
    logic                 out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg <= COORD_W'(655360);
            box_y_reg <= COORD_W'(655360);
            box_z_reg <= COORD_W'(655360);
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BOX_X: box_x_reg <= cfg_data;
                CFG_BOX_Y: box_y_reg <= cfg_data;
                CFG_BOX_Z: box_z_reg <= cfg_data;
                CFG_COUNT: count_reg <= cfg_data[PCOUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Particles beyond the store are never checked.
    always_comb
    begin
        count_ext = IDX_W'(count_reg);
        limit     = (count_ext > MAX_IDX) ? MAX_IDX : count_ext;
        rows      = (limit + IDX_W'(CELLS - 1)) >> CELL_BITS;
        rows_w    = rows[RCNT_W-1:0];
    end

    assign cfg.box_x = box_x_reg;
    assign cfg.box_y = box_y_reg;
    assign cfg.box_z = box_z_reg;
    assign cfg.limit = limit;

    assign wr.en   = (state_reg == ST_EXEC) && (op_reg == OP_LOAD)
                     && (IDX_W'(slot_reg) < MAX_IDX);
    assign wr.slot = IDX_W'(slot_reg);
    assign wr.x    = px_reg;
    assign wr.y    = py_reg;
    assign wr.z    = pz_reg;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        ovl_next       = ovl_reg | (chain_tok.valid & chain_tok.hit);
        issue_tok_next = '0;
        out_valid_next = out_valid_reg && !out_ready;
        overlap_next   = overlap_reg;
        acc_next       = acc_reg;
        trial_next     = trial_reg;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                ovl_next = 1'b0;
                row_next = '0;
                if ((op_reg == OP_TEST) && (rows_w != '0))
                    state_next = ST_SWEEP;
                else
                    state_next = ST_FINISH;
            end
            ST_SWEEP:
            begin
                issue_tok_next.valid = 1'b1;
                issue_tok_next.last  = (row_reg == rows_w - RCNT_W'(1));
                issue_tok_next.row   = ROW_FIELD_W'(row_reg);
                issue_tok_next.px    = px_reg;
                issue_tok_next.py    = py_reg;
                issue_tok_next.pz    = pz_reg;
                row_next             = row_reg + RCNT_W'(1);
                if (issue_tok_next.last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (chain_tok.valid && chain_tok.last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    overlap_next   = 1'b0;
                    case (op_reg)
                        OP_TEST:
                        begin
                            overlap_next = ovl_reg;
                            if (trial_reg != SAT)
                                trial_next = trial_reg + CNT_W'(1);
                            if (!ovl_reg && (acc_reg != SAT))
                                acc_next = acc_reg + CNT_W'(1);
                        end
                        OP_CLEAR:
                        begin
                            trial_next = '0;
                            acc_next   = '0;
                        end
                        default: ;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            ovl_reg       <= 1'b0;
            issue_tok_reg <= '0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            trial_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            ovl_reg       <= ovl_next;
            issue_tok_reg <= issue_tok_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            trial_reg     <= trial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        overlap_reg <= overlap_next;
        if (in_ready && in_valid)
        begin
            op_reg   <= operation;
            slot_reg <= slot;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
        end
    end

    assign issue_tok      = issue_tok_reg;
    assign out_valid      = out_valid_reg;
    assign overlap        = overlap_reg;
    assign accepted_count = acc_reg;
    assign trial_count    = trial_reg;

endmodule

`default_nettype wire

[rtl/core/hard_sphere_insertion_overlap.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "hard_sphere_insertion_overlap_assert.svh"

// Hard-sphere insertion overlap checker. Particle positions sit in a chain of
// four cells, each holding every fourth slot in its own memory; a test token
// carrying the trial position walks down the chain once per stored row and
// picks up a hit flag in any cell where the minimum-image squared distance is
// below one. One transaction is handled at a time. A load, clear or unknown
// operation, and a test with no particles to check, goes from the execute
// state to the finish state, which raises out_valid once the output register
// is free; the next input transaction can be taken as out_valid rises. A test
// with n particles checked, n being particle_count capped at the store size,
// sweeps its ceil(n/4) rows, one per cycle, out of the cell memories through
// five pipeline stages in each of the four cells, and waits for the last token
// before the finish state. The particle store is not cleared at reset, so no
// test may check a slot that has not been loaded. A finished result waits in
// the output register without holding up the next input transaction.
module hard_sphere_insertion_overlap
    import hsio_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [COORD_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [COORD_W-1:0] pos_x,
    input  wire logic [COORD_W-1:0] pos_y,
    input  wire logic [COORD_W-1:0] pos_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    overlap,
    output logic [CNT_W-1:0]        accepted_count,
    output logic [CNT_W-1:0]        trial_count
);

    cfg_t cfg;
    wr_t  wr;
    tok_t chain [CELLS+1];

    hsio_ctrl #(
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .slot           (slot),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .overlap        (overlap),
        .accepted_count (accepted_count),
        .trial_count    (trial_count),
        .cfg            (cfg),
        .wr             (wr),
        .issue_tok      (chain[0]),
        .chain_tok      (chain[CELLS])
    );

    for (genvar c = 0; c < CELLS; c++)
    begin : g_cell
        hsio_cell #(
            .CELL_INDEX    (c),
            .MAX_PARTICLES (MAX_PARTICLES),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg),
            .wr      (wr),
            .tok_in  (chain[c]),
            .tok_out (chain[c+1])
        );
    end

    // The chain must be empty whenever a new transaction can be taken.
    `HSIO_ASSERT_NOW(a_chain_empty_when_ready, clk, rst_n, chain[CELLS].valid, !in_ready)
    `HSIO_ASSERT_NOW(a_issue_only_when_busy, clk, rst_n, chain[0].valid, !in_ready)
    `HSIO_ASSERT_NOW(a_accepted_le_trials, clk, rst_n, out_valid, accepted_count <= trial_count)

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import hsio_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int UNIT_SHIFT = 32;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_WAIT = 13;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam coord_t TEN_UNITS = 24'h0A0000;
    localparam coord_t MAX_COORD = 24'hFFFFFF;

    typedef struct packed {
        logic   overlap;
        count_t accepted;
        count_t trials;
    } outcome_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    coord_t              cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          operation;
    logic [SLOT_W-1:0]   slot;
    coord_t              pos_x;
    coord_t              pos_y;
    coord_t              pos_z;
    logic                out_valid;
    logic                out_ready;
    logic                overlap;
    count_t              accepted_count;
    count_t              trial_count;

    // Local copy of the block's registers and particle store.
    coord_t              box_x_cfg = TEN_UNITS;
    coord_t              box_y_cfg = TEN_UNITS;
    coord_t              box_z_cfg = TEN_UNITS;
    logic [PCOUNT_W-1:0] checked_count = '0;
    coord_t              stored_x [STORE_DEPTH];
    coord_t              stored_y [STORE_DEPTH];
    coord_t              stored_z [STORE_DEPTH];
    count_t              accepted_total = '0;
    count_t              trial_total = '0;

    outcome_t            pending_outcomes [$];
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count = 0;
    int unsigned         hold_off_cycles = 0;
    bit                  no_idle = 1'b0;

    hard_sphere_insertion_overlap uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .slot           (slot),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .overlap        (overlap),
        .accepted_count (accepted_count),
        .trial_count    (trial_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    // Minimum-image difference with a single correction step, no wrap into the box.
    function automatic longint image_delta(input coord_t p, input coord_t q, input coord_t span);
        longint d;
        longint b;
        d = longint'(p) - longint'(q);
        b = longint'(span);
        if (2 * d > b)
            d = d - b;
        else if (2 * d < -b)
            d = d + b;
        return d;
    endfunction

    function automatic logic trial_overlaps(input coord_t x, input coord_t y, input coord_t z);
        int unsigned n;
        longint      dx;
        longint      dy;
        longint      dz;
        n = (checked_count > STORE_DEPTH) ? STORE_DEPTH : checked_count;
        for (int i = 0; i < n; i++)
        begin
            dx = image_delta(x, stored_x[i], box_x_cfg);
            dy = image_delta(y, stored_y[i], box_y_cfg);
            dz = image_delta(z, stored_z[i], box_z_cfg);
            if (dx * dx + dy * dy + dz * dz < (longint'(1) << UNIT_SHIFT))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_insertion(input logic [1:0] op, input logic [SLOT_W-1:0] where,
                                     input coord_t x, input coord_t y, input coord_t z);
        outcome_t outcome;
        outcome.overlap = 1'b0;
        case (op)
            OP_LOAD:
            begin
                stored_x[where] = x;
                stored_y[where] = y;
                stored_z[where] = z;
            end
            OP_TEST:
            begin
                outcome.overlap = trial_overlaps(x, y, z);
                if (trial_total != '1)
                    trial_total++;
                if (!outcome.overlap && accepted_total != '1)
                    accepted_total++;
            end
            OP_CLEAR:
            begin
                accepted_total = '0;
                trial_total = '0;
            end
            default:
            begin
            end
        endcase
        outcome.accepted = accepted_total;
        outcome.trials = trial_total;
        pending_outcomes.push_back(outcome);
    endtask

    // Leaves in_valid high so that a following item can go out back to back.
    task automatic send_item(input logic [1:0] op, input logic [SLOT_W-1:0] where,
                             input coord_t x, input coord_t y, input coord_t z);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        slot <= where;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do
            @(posedge clk);
        while (!in_ready);
        predict_insertion(op, where, x, y, z);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input coord_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_BOX_X: box_x_cfg = value;
            CFG_BOX_Y: box_y_cfg = value;
            CFG_BOX_Z: box_z_cfg = value;
            CFG_COUNT: checked_count = value[PCOUNT_W-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic write_box(input coord_t bx, input coord_t by, input coord_t bz);
        write_reg(CFG_BOX_X, bx);
        write_reg(CFG_BOX_Y, by);
        write_reg(CFG_BOX_Z, bz);
    endtask

    // A point within about one and a half units of centre, sometimes one box length away.
    function automatic coord_t jitter(input coord_t centre, input coord_t span);
        int offset;
        offset = int'($urandom_range(0, 3 * 65536)) - 3 * 32768;
        case ($urandom_range(0, 5))
            0: return COORD_W'(centre + span + offset);
            1: return COORD_W'(centre - span + offset);
            default: return COORD_W'(centre + offset);
        endcase
    endfunction

    function automatic coord_t random_position(input coord_t span);
        if (span != 0 && $urandom_range(0, 3) != 0)
            return COORD_W'($urandom_range(0, span - 1));
        return COORD_W'($urandom);
    endfunction

    task automatic send_near_trial();
        int unsigned n;
        int unsigned idx;
        n = (checked_count > STORE_DEPTH) ? STORE_DEPTH : checked_count;
        if (n == 0)
        begin
            send_item(OP_TEST, SLOT_W'($urandom), random_position(box_x_cfg),
                      random_position(box_y_cfg), random_position(box_z_cfg));
        end
        else
        begin
            idx = $urandom_range(0, n - 1);
            send_item(OP_TEST, SLOT_W'($urandom), jitter(stored_x[idx], box_x_cfg),
                      jitter(stored_y[idx], box_y_cfg), jitter(stored_z[idx], box_z_cfg));
        end
    endtask

    // Only safe once every slot has been loaded.
    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_near_trial();
        else if (pick < 60)
            send_item(OP_TEST, SLOT_W'($urandom), random_position(box_x_cfg),
                      random_position(box_y_cfg), random_position(box_z_cfg));
        else if (pick < 88)
            send_item(OP_LOAD, SLOT_W'($urandom), random_position(box_x_cfg),
                      random_position(box_y_cfg), random_position(box_z_cfg));
        else if (pick < 94)
            send_item(OP_CLEAR, SLOT_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom));
        else
            send_item(OP_UNKNOWN, SLOT_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Output sink: draws a stall for every transaction and honours a requested hold-off.
    initial
    begin
        int unsigned stall;
        out_ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result transaction with nothing expected");
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (overlap !== want.overlap)
                    report_mismatch($sformatf("overlap %0b, expected %0b",
                                              overlap, want.overlap));
                if (accepted_count !== want.accepted)
                    report_mismatch($sformatf("accepted_count %0d, expected %0d",
                                              accepted_count, want.accepted));
                if (trial_count !== want.trials)
                    report_mismatch($sformatf("trial_count %0d, expected %0d",
                                              trial_count, want.trials));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("hard_sphere_insertion_overlap test failed");
        $finish;
    end

    // With nothing stored every trial is accepted, whatever the position.
    task automatic test_empty_store();
        send_item(OP_TEST, '0, '0, '0, '0);
        send_item(OP_TEST, '1, MAX_COORD, MAX_COORD, MAX_COORD);
        send_item(OP_UNKNOWN, '1, MAX_COORD, MAX_COORD, MAX_COORD);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_TEST, 10'h155, 24'h555555, 24'hAAAAAA, 24'h555555);
        wait_drained();
    endtask

    task automatic test_unit_threshold();
        send_item(OP_LOAD, 10'd0, 24'h050000, 24'h050000, 24'h050000);
        send_item(OP_LOAD, 10'd1, 24'h09C000, 24'h09C000, 24'h09C000);
        wait_drained();
        write_reg(CFG_COUNT, 24'd2);
        // Exactly one unit away on either side is not an overlap; one step inside is.
        send_item(OP_TEST, '0, 24'h060000, 24'h050000, 24'h050000);
        send_item(OP_TEST, '0, 24'h040000, 24'h050000, 24'h050000);
        send_item(OP_TEST, '0, 24'h05FFFF, 24'h050000, 24'h050000);
        // Images across the lower boundary and from beyond the box.
        send_item(OP_TEST, '0, 24'h004000, 24'h004000, 24'h004000);
        send_item(OP_TEST, '0, 24'h0E8000, 24'h0E8000, 24'h0E8000);
        send_item(OP_TEST, '0, 24'h02C000, 24'h02C000, 24'h02C000);
        send_item(OP_TEST, '0, MAX_COORD, MAX_COORD, MAX_COORD);
        wait_drained();
    endtask

    task automatic test_box_extremes();
        write_box('0, '0, '0);
        send_item(OP_TEST, '0, 24'h058000, 24'h050000, 24'h050000);
        send_item(OP_TEST, '0, 24'h004000, 24'h004000, 24'h004000);
        send_item(OP_TEST, '0, MAX_COORD, '0, MAX_COORD);
        wait_drained();
        write_box(MAX_COORD, MAX_COORD, MAX_COORD);
        send_item(OP_TEST, '0, 24'h058000, 24'h058000, 24'h050000);
        send_item(OP_TEST, '0, MAX_COORD, MAX_COORD, MAX_COORD);
        send_item(OP_TEST, '0, 24'h004000, 24'h004000, 24'h004000);
        wait_drained();
        write_box(TEN_UNITS, TEN_UNITS, TEN_UNITS);
    endtask

    task automatic test_full_store();
        for (int s = 0; s < STORE_DEPTH; s++)
        begin
            no_idle = (s >= STORE_DEPTH / 2);
            send_item(OP_LOAD, SLOT_W'(s), random_position(box_x_cfg),
                      random_position(box_y_cfg), random_position(box_z_cfg));
        end
        no_idle = 1'b0;
        wait_drained();
        write_reg(CFG_COUNT, COORD_W'(STORE_DEPTH));
        repeat (3) send_near_trial();
        repeat (3) send_item(OP_TEST, '0, COORD_W'($urandom), COORD_W'($urandom),
                             COORD_W'($urandom));
        wait_drained();
        // Counts beyond the store check only the store.
        write_reg(CFG_COUNT, 24'h0007FF);
        repeat (2) send_near_trial();
        repeat (2) send_item(OP_TEST, '0, COORD_W'($urandom), COORD_W'($urandom),
                             COORD_W'($urandom));
        wait_drained();
        write_reg(CFG_COUNT, COORD_W'(STORE_DEPTH + 1));
        send_near_trial();
        send_item(OP_TEST, '0, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        wait_drained();
    endtask

    // The sink holds off while items keep coming, so the block fills and stops taking input.
    task automatic test_result_hold_off();
        write_reg(CFG_COUNT, 24'd8);
        hold_off_cycles = 300;
        no_idle = 1'b1;
        repeat (12) random_item();
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic(input int segments);
        coord_t              noise;
        logic [PCOUNT_W-1:0] count;
        coord_t              spans [3];
        int unsigned         items;
        for (int seg = 0; seg < segments; seg++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                case ($urandom_range(0, 5))
                    0: spans[a] = TEN_UNITS;
                    1: spans[a] = '0;
                    2: spans[a] = MAX_COORD;
                    3: spans[a] = COORD_W'($urandom);
                    default: spans[a] = COORD_W'($urandom_range(2 * 65536, 40 * 65536));
                endcase
            end
            case ($urandom_range(0, 9))
                0: count = PCOUNT_W'($urandom_range(STORE_DEPTH + 1, 2047));
                1: count = PCOUNT_W'($urandom_range(17, STORE_DEPTH));
                2: count = '0;
                default: count = PCOUNT_W'($urandom_range(1, 16));
            endcase
            noise = COORD_W'($urandom);
            write_box(spans[0], spans[1], spans[2]);
            write_reg(CFG_COUNT, {noise[COORD_W-1:PCOUNT_W], count});
            no_idle = ($urandom_range(0, 4) == 0);
            items = $urandom_range(80, 120);
            repeat (items)
            begin
                random_item();
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
            no_idle = 1'b0;
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BOX_X;
        cfg_data <= '0;
        in_valid <= 1'b0;
        operation <= OP_LOAD;
        slot <= '0;
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_unit_threshold();
        test_box_extremes();
        test_full_store();
        test_result_hold_off();
        test_random_traffic(8);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("hard_sphere_insertion_overlap test passed");
        else
            $display("hard_sphere_insertion_overlap test failed");
        $finish;
    end

endmodule

[hard_sphere_insertion_overlap.f]
+incdir+rtl/core
rtl/core/hsio_pkg.sv
rtl/core/hsio_cell.sv
rtl/core/hsio_ctrl.sv
rtl/core/hard_sphere_insertion_overlap.sv
tb/tb.sv
